@@ sv/rgbspe_pkg.sv @@
// shared types and constants for the rgb led serial pulse encoder
`default_nettype none
package rgbspe_pkg;

    localparam int BITS_PER_FRAME = 24;
    localparam int COLOR_W        = 24;
    localparam int PERIOD_W       = 16;
    localparam int TICK_W         = 24;
    localparam int CFG_DATA_W     = 24;
    localparam int CFG_INDEX_W    = 2;
    localparam int BITS_LEFT_W    = $clog2(BITS_PER_FRAME + 1);

    localparam logic [CFG_INDEX_W-1:0] CFG_BIT_PERIOD  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_THRESH = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ONE_THRESH  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESET_TICKS = 2'd3;

    localparam logic [PERIOD_W-1:0] BIT_PERIOD_RST  = 16'd240;
    localparam logic [PERIOD_W-1:0] ZERO_THRESH_RST = 16'd164;
    localparam logic [PERIOD_W-1:0] ONE_THRESH_RST  = 16'd87;
    localparam logic [TICK_W-1:0]   RESET_TICKS_RST = 24'd57600;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_RESET = 2'd1,
        PH_BITS  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] bit_period_ticks;
        logic [PERIOD_W-1:0] zero_threshold;
        logic [PERIOD_W-1:0] one_threshold;
        logic [TICK_W-1:0]   reset_ticks;
    } cfg_t;

    typedef struct packed {
        phase_t                    phase;
        logic [TICK_W-1:0]         tick_count;
        logic [BITS_PER_FRAME-1:0] shift_word;
        logic [BITS_LEFT_W-1:0]    bits_left;
        logic                      pulse_high;
    } enc_state_t;

    typedef struct packed {
        logic pin_level;
        logic busy_res;
        logic frame_done;
    } result_t;

endpackage
`default_nettype wire

@@ sv/rgbspe_ifs.sv @@
// valid/ready stream interfaces for the tick input and the result output
`default_nettype none
interface rgbspe_in_if;
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic [rgbspe_pkg::COLOR_W-1:0] color;

    modport source (output valid, output mode, output color, input ready);
    modport sink (input valid, input mode, input color, output ready);
endinterface

interface rgbspe_out_if;
    logic valid;
    logic ready;
    logic pin_level;
    logic busy_res;
    logic frame_done;

    modport source (output valid, output pin_level, output busy_res, output frame_done,
                    input ready);
    modport sink (input valid, input pin_level, input busy_res, input frame_done,
                  output ready);
endinterface
`default_nettype wire

@@ sv/rgbspe_cfg.sv @@
// configuration register bank
`default_nettype none
module rgbspe_cfg (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [rgbspe_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [rgbspe_pkg::CFG_DATA_W-1:0]   cfg_data,
    output rgbspe_pkg::cfg_t                         cfg
);

    rgbspe_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_period_ticks <= rgbspe_pkg::BIT_PERIOD_RST;
            cfg_reg.zero_threshold   <= rgbspe_pkg::ZERO_THRESH_RST;
            cfg_reg.one_threshold    <= rgbspe_pkg::ONE_THRESH_RST;
            cfg_reg.reset_ticks      <= rgbspe_pkg::RESET_TICKS_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                rgbspe_pkg::CFG_BIT_PERIOD:
                    cfg_reg.bit_period_ticks <= cfg_data[rgbspe_pkg::PERIOD_W-1:0];
                rgbspe_pkg::CFG_ZERO_THRESH:
                    cfg_reg.zero_threshold <= cfg_data[rgbspe_pkg::PERIOD_W-1:0];
                rgbspe_pkg::CFG_ONE_THRESH:
                    cfg_reg.one_threshold <= cfg_data[rgbspe_pkg::PERIOD_W-1:0];
                rgbspe_pkg::CFG_RESET_TICKS:
                    cfg_reg.reset_ticks <= cfg_data[rgbspe_pkg::TICK_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

@@ sv/rgbspe_step.sv @@
// next-state and result logic for one tick of the encoder
`default_nettype none
module rgbspe_step (
    input  wire rgbspe_pkg::cfg_t                    cfg,
    input  wire rgbspe_pkg::enc_state_t              state,
    input  wire logic                                mode,
    input  wire logic [rgbspe_pkg::COLOR_W-1:0]      color,
    output rgbspe_pkg::enc_state_t                   state_next,
    output rgbspe_pkg::result_t                      result
);

    logic [rgbspe_pkg::PERIOD_W-1:0]    thr;
    logic [rgbspe_pkg::BITS_LEFT_W-1:0] bits_dec;
    logic [31:0]                        color_ext;
    logic                               wrap;

    assign color_ext = 32'(color);
    assign wrap      = (state.tick_count == '0);
    assign thr       = state.shift_word[rgbspe_pkg::BITS_PER_FRAME-1] ?
                       cfg.one_threshold : cfg.zero_threshold;
    assign bits_dec  = (state.bits_left != '0) ?
                       state.bits_left - rgbspe_pkg::BITS_LEFT_W'(1) : '0;

    always_comb
    begin
        state_next = state;
        result     = '0;
        unique case (state.phase)
            rgbspe_pkg::PH_RESET:
            begin
                result.busy_res = 1'b1;
                if (wrap)
                begin
                    state_next.phase      = rgbspe_pkg::PH_BITS;
                    state_next.tick_count = rgbspe_pkg::TICK_W'(cfg.bit_period_ticks);
                    state_next.pulse_high = 1'b1;
                end
                else
                begin
                    state_next.tick_count = state.tick_count - rgbspe_pkg::TICK_W'(1);
                end
            end
            rgbspe_pkg::PH_BITS:
            begin
                result.busy_res = 1'b1;
                if (state.pulse_high)
                begin
                    if (state.tick_count > rgbspe_pkg::TICK_W'(thr))
                    begin
                        result.pin_level = 1'b1;
                    end
                    else
                    begin
                        // falling edge of this bit's pulse
                        state_next.pulse_high = 1'b0;
                        state_next.shift_word = state.shift_word << 1;
                        state_next.bits_left  = bits_dec;
                        if (bits_dec == '0)
                        begin
                            result.frame_done = 1'b1;
                            state_next.phase  = rgbspe_pkg::PH_IDLE;
                        end
                    end
                end
                if (state_next.phase == rgbspe_pkg::PH_BITS)
                begin
                    if (wrap)
                    begin
                        state_next.tick_count =
                            rgbspe_pkg::TICK_W'(cfg.bit_period_ticks);
                        state_next.pulse_high = 1'b1;
                    end
                    else
                    begin
                        state_next.tick_count = state.tick_count - rgbspe_pkg::TICK_W'(1);
                    end
                end
                else
                begin
                    state_next.tick_count = '0;
                end
            end
            default:
            begin
                // idle, and the unused phase code behaves as idle
                state_next.phase = rgbspe_pkg::PH_IDLE;
                if (mode)
                begin
                    result.busy_res       = 1'b1;
                    state_next.phase      = rgbspe_pkg::PH_RESET;
                    state_next.tick_count = cfg.reset_ticks;
                    state_next.shift_word = color_ext[rgbspe_pkg::BITS_PER_FRAME-1:0];
                    state_next.bits_left  =
                        rgbspe_pkg::BITS_LEFT_W'(rgbspe_pkg::BITS_PER_FRAME);
                    state_next.pulse_high = 1'b0;
                end
            end
        endcase
    end

endmodule
`default_nettype wire

@@ sv/rgb_led_serial_pulse_encoder_unit.sv @@
// top level of the rgb led serial pulse encoder
//
//   channel  direction  transaction carries
//   in_ch    in         mode, color (one tick)
//   out_ch   out        pin_level, busy_res, frame_done (one per tick)
//   cfg_*    in         write of one configuration register, no wait
//
// every tick passes through an input register, then the tick logic into the
// output register. one tick is accepted per cycle while the output side keeps
// up; a stalled output register holds the tick stage and then the input.
// rst_n clears the encoder to idle and loads the default configuration.
`default_nettype none
module rgb_led_serial_pulse_encoder_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wr_en,
    input  wire logic [rgbspe_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [rgbspe_pkg::CFG_DATA_W-1:0]   cfg_data,
    rgbspe_in_if.sink                                in_ch,
    rgbspe_out_if.source                             out_ch
);

    rgbspe_pkg::cfg_t        cfg;
    rgbspe_pkg::enc_state_t  state_reg;
    rgbspe_pkg::enc_state_t  state_next;
    rgbspe_pkg::result_t     result_next;
    rgbspe_pkg::result_t     result_reg;

    logic                             s1_valid_reg;
    logic                             s1_mode_reg;
    logic [rgbspe_pkg::COLOR_W-1:0]   s1_color_reg;
    logic                             out_valid_reg;
    logic                             s1_adv;
    logic                             in_take;

    rgbspe_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rgbspe_step u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .mode       (s1_mode_reg),
        .color      (s1_color_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // tick stage moves on when the output register is empty or being drained
    assign s1_adv      = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || s1_adv;
    assign in_take     = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{phase: rgbspe_pkg::PH_IDLE, default: '0};
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_mode_reg  <= in_ch.mode;
            s1_color_reg <= in_ch.color;
        end
        if (s1_adv)
        begin
            result_reg <= result_next;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.pin_level  = result_reg.pin_level;
    assign out_ch.busy_res   = result_reg.busy_res;
    assign out_ch.frame_done = result_reg.frame_done;

endmodule
`default_nettype wire

@@ sv/rgbspe_checker.sv @@
// port-level checks for the encoder top level, bound to it
`default_nettype none
module rgbspe_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic pin_level,
    input wire logic busy_res,
    input wire logic frame_done
);

    // a high pin only appears inside a frame
    a_pin_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && pin_level) |-> busy_res)
        else $error("pin high outside a frame");

    // the end of a frame is a low, busy tick
    a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_done) |-> (busy_res && !pin_level))
        else $error("frame_done on a tick that is not busy or has pin high");

    // with an empty output register the input side never stalls
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output register is empty");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(pin_level) && $stable(busy_res) && $stable(frame_done)))
        else $error("stalled output transaction changed");

endmodule

bind rgb_led_serial_pulse_encoder_unit rgbspe_checker u_rgbspe_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .pin_level  (out_ch.pin_level),
    .busy_res   (out_ch.busy_res),
    .frame_done (out_ch.frame_done)
);
`default_nettype wire
